// File: rtl/core/smts_pkg.sv
// smts_pkg: opcodes, status codes and sequencer states of the triple store
// no dependencies
`timescale 1ns / 1ps
package smts_pkg;
  localparam int ROW_W = 8;
  localparam int COL_W = 8;
  localparam int VAL_W = 32;
  localparam int ENT_W = ROW_W + COL_W + VAL_W;

  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_SEARCH = 3'd3,
    OP_DELETE = 3'd4
  } opcode_t;

  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_ZERO = 2'd1,
    ST_MISS = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_REPORT
  } state_t;
endpackage

// File: rtl/core/smts_mem.sv
// smts_mem: entry storage, one write port and one registered read port
// depends on smts_pkg
`timescale 1ns / 1ps
module smts_mem #(
  parameter int DEPTH = 64,
  parameter int AW = 6
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [smts_pkg::ENT_W-1:0] wdata,
  input  logic [AW-1:0]            raddr,
  output logic [smts_pkg::ENT_W-1:0] rdata
);
  import smts_pkg::*;
  logic [ENT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// File: rtl/core/sparse_matrix_triple_store_unit.sv
// sequencing: clear, refused append/insert and append go from S_IDLE to S_REPORT;
// search steps S_SCAN_RD, S_SCAN_CMP per entry; insert S_SHIFT_RD, S_SHIFT_WR per
// moved entry; delete scans then shifts, each bounded by the single memory read port
// throughput: one command at a time, busy high until its result strobe
// reset: synchronous active-low rst_n empties the list; storage itself is not cleared
`timescale 1ns / 1ps
module sparse_matrix_triple_store_unit #(
  parameter int DEPTH = 64,
  parameter int MAX_ROWS = 256,
  parameter int MAX_COLS = 256
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [2:0]                 in_opcode,
  input  logic [7:0]                 in_row_index,
  input  logic [7:0]                 in_col_index,
  input  logic signed [31:0]         in_elem_value,
  output logic                       out_valid,
  output logic signed [31:0]         out_found_value,
  output logic [1:0]                 out_status
);
  import smts_pkg::*;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [2:0] op_r;
  logic [ROW_W-1:0] row_r;
  logic [COL_W-1:0] col_r;
  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] fv_r, fv_nxt;
  logic [1:0] st_r, st_nxt;
  logic del_r, del_nxt;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [ENT_W-1:0] wdata, rdata;

  smts_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  logic in_range, full, hit;
  assign in_range = (32'(in_row_index) < 32'(MAX_ROWS)) &&
                    (32'(in_col_index) < 32'(MAX_COLS));
  assign full = (32'(count_r) >= 32'(DEPTH));
  assign hit  = (rdata[ENT_W-1 -: ROW_W] == row_r) &&
                (rdata[VAL_W +: COL_W] == col_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    count_nxt = count_r;
    idx_nxt = idx_r;
    fv_nxt = fv_r;
    st_nxt = st_r;
    del_nxt = del_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          fv_nxt = '0;
          st_nxt = ST_DONE;
          del_nxt = 1'b0;
          state_nxt = S_REPORT;
          case (in_opcode)
            OP_CLEAR: count_nxt = '0;
            OP_APPEND: begin
              if (in_elem_value == 0 || !in_range) st_nxt = ST_ZERO;
              else if (full) st_nxt = ST_FULL;
              else count_nxt = count_r + 1'b1;
            end
            OP_INSERT: begin
              if (!in_range) st_nxt = ST_ZERO;
              else if (full) st_nxt = ST_FULL;
              else if (count_r == 0) count_nxt = count_r + 1'b1;
              else begin
                idx_nxt = count_r;
                state_nxt = S_SHIFT_RD;
              end
            end
            OP_SEARCH, OP_DELETE: begin
              idx_nxt = '0;
              st_nxt = ST_MISS;
              if (count_r != 0) state_nxt = S_SCAN_RD;
            end
            default: ;
          endcase
        end
      end
      S_SCAN_RD: state_nxt = S_SCAN_CMP;
      S_SCAN_CMP: begin
        if (hit) begin
          st_nxt = ST_DONE;
          if (op_r == OP_SEARCH) begin
            fv_nxt = rdata[VAL_W-1:0];
            state_nxt = S_REPORT;
          end else begin
            del_nxt = 1'b1;
            if (idx_r + 1'b1 >= count_r) begin
              count_nxt = count_r - 1'b1;
              state_nxt = S_REPORT;
            end else begin
              idx_nxt = idx_r + 1'b1;
              state_nxt = S_SHIFT_RD;
            end
          end
        end else if (idx_r + 1'b1 >= count_r) state_nxt = S_REPORT;
        else begin
          idx_nxt = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SHIFT_RD: state_nxt = S_SHIFT_WR;
      S_SHIFT_WR: begin
        if (del_r) begin
          // slot idx moves down to idx-1
          if (idx_r + 1'b1 >= count_r) begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_REPORT;
          end else begin
            idx_nxt = idx_r + 1'b1;
            state_nxt = S_SHIFT_RD;
          end
        end else begin
          // slot idx-1 moves up to idx
          if (idx_r == 1) begin
            idx_nxt = '0;
            count_nxt = count_r + 1'b1;
            state_nxt = S_REPORT;
          end else begin
            idx_nxt = idx_r - 1'b1;
            state_nxt = S_SHIFT_RD;
          end
        end
      end
      S_REPORT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memory port and outputs
  always_comb begin
    we = 1'b0;
    waddr = idx_r[AW-1:0];
    wdata = {row_r, col_r, val_r};
    raddr = idx_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        waddr = count_r[AW-1:0];
        wdata = {in_row_index, in_col_index, in_elem_value};
        we = start && (in_opcode == OP_APPEND) && in_elem_value != 0 && in_range && !full;
        // insert into an empty list writes the head directly
        if (start && in_opcode == OP_INSERT && in_range && count_r == 0) begin
          we = 1'b1;
          waddr = '0;
        end
      end
      S_SHIFT_RD: raddr = del_r ? idx_r[AW-1:0] : AW'(idx_r - 1'b1);
      S_SHIFT_WR: begin
        we = 1'b1;
        wdata = rdata;
        waddr = del_r ? AW'(idx_r - 1'b1) : idx_r[AW-1:0];
      end
      S_REPORT: begin
        // insert finishes by writing the head
        we = (op_r == OP_INSERT) && (st_r == ST_DONE) && (idx_r == 0) && !del_r &&
             count_r != 0;
        waddr = '0;
      end
      default: ;
    endcase
  end

  assign busy = (state_r != S_IDLE);
  assign out_valid = (state_r == S_REPORT);
  assign out_found_value = fv_r;
  assign out_status = st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      idx_r <= '0;
      del_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      idx_r <= idx_nxt;
      del_r <= del_nxt;
    end
    fv_r <= fv_nxt;
    st_r <= st_nxt;
    if (state_r == S_IDLE && start) begin
      op_r <= in_opcode;
      row_r <= in_row_index;
      col_r <= in_col_index;
      val_r <= in_elem_value;
    end
  end
endmodule

// File: rtl/core/smts_checker.sv
// smts_checker: port-level checks of the triple store, bound to the top level
// depends on smts_pkg
`timescale 1ns / 1ps
module smts_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [2:0]  in_opcode,
  input logic        out_valid,
  input logic [31:0] out_found_value,
  input logic [1:0]  out_status
);
  import smts_pkg::*;

  // a result beat only ends a command
  a_valid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result beat while idle");
  a_drop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
  a_fv: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_DONE) |-> out_found_value == 0)
    else $error("nonzero value on failure");
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("command not taken");
  // clear answers right away with done
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_opcode == OP_CLEAR) |=> (out_valid && out_status == ST_DONE))
    else $error("clear not answered next cycle");
endmodule

bind sparse_matrix_triple_store_unit smts_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_opcode(in_opcode),
  .out_valid(out_valid), .out_found_value(out_found_value), .out_status(out_status)
);

// File: tb/sv/tb_sparse_matrix_triple_store_unit.sv
// tb_sparse_matrix_triple_store_unit: random and directed command test of the triple store
// checks every result beat against a predicted list; depends on smts_pkg and the unit
`timescale 1ns / 1ps
module tb_sparse_matrix_triple_store_unit;
  import smts_pkg::*;

  localparam int DEPTH = 64;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] value;
    logic               drain;
  } command_t;

  typedef struct packed {
    logic signed [31:0] found;
    logic [1:0]         status;
  } answer_t;

  typedef struct packed {
    logic [7:0]         row;
    logic [7:0]         col;
    logic signed [31:0] value;
  } triple_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [2:0] in_opcode;
  logic [7:0] in_row_index;
  logic [7:0] in_col_index;
  logic signed [31:0] in_elem_value;
  logic out_valid;
  logic signed [31:0] out_found_value;
  logic [1:0] out_status;

  command_t pending_cmds[$];
  answer_t expected_answers[$];
  triple_t model_list[$];
  int error_count = 0;
  int cycle_count = 0;
  int gap_left = 0;

  sparse_matrix_triple_store_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_row_index(in_row_index),
    .in_col_index(in_col_index), .in_elem_value(in_elem_value),
    .out_valid(out_valid), .out_found_value(out_found_value),
    .out_status(out_status)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    error_count++;
  endtask

  // predicted list, slot 0 at the head
  function automatic answer_t apply_command(command_t c);
    answer_t a;
    int slot;
    a.found = '0;
    a.status = ST_DONE;
    slot = -1;
    foreach (model_list[i])
      if (slot < 0 && model_list[i].row == c.row && model_list[i].col == c.col) slot = i;
    case (c.opcode)
      OP_CLEAR: model_list.delete();
      OP_APPEND: begin
        if (c.value == 0) a.status = ST_ZERO;
        else if (model_list.size() >= DEPTH) a.status = ST_FULL;
        else model_list.push_back('{c.row, c.col, c.value});
      end
      OP_INSERT: begin
        if (model_list.size() >= DEPTH) a.status = ST_FULL;
        else model_list.push_front('{c.row, c.col, c.value});
      end
      OP_SEARCH: begin
        if (slot >= 0) a.found = model_list[slot].value;
        else a.status = ST_MISS;
      end
      OP_DELETE: begin
        if (slot >= 0) model_list.delete(slot);
        else a.status = ST_MISS;
      end
      default: ;
    endcase
    return a;
  endfunction

  function automatic command_t make_cmd(logic [2:0] op, logic [7:0] r, logic [7:0] c,
                                        logic signed [31:0] v);
    command_t k;
    k.opcode = op;
    k.row = r;
    k.col = c;
    k.value = v;
    k.drain = 0;
    return k;
  endfunction

  function automatic logic signed [31:0] rand_value();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return 32'sh8000_0000;
      2: return 32'sh7fff_ffff;
      3: return -1;
      default: return $urandom();
    endcase
  endfunction

  // driver: hold a command until busy drops, then idle for a random gap
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 0;
    end else begin
      cycle_count <= cycle_count + 1;
      if (start && !busy) begin
        void'(pending_cmds.pop_front());
        start <= 0;
        gap_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
                    (($urandom_range(0, 2) == 0) ? $urandom_range(0, 3) : 0);
      end else if (!start && pending_cmds.size() > 0) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
        end else if (!pending_cmds[0].drain || expected_answers.size() == 0) begin
          if (pending_cmds[0].drain) begin
            void'(pending_cmds.pop_front());
          end else begin
            start <= 1;
            in_opcode <= pending_cmds[0].opcode;
            in_row_index <= pending_cmds[0].row;
            in_col_index <= pending_cmds[0].col;
            in_elem_value <= pending_cmds[0].value;
            expected_answers.push_back(apply_command(pending_cmds[0]));
          end
        end
      end
      if (cycle_count > CYCLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_answers.size() == 0) begin
        report_mismatch("result beat with nothing expected");
      end else begin
        answer_t e;
        e = expected_answers.pop_front();
        if (out_found_value !== e.found)
          report_mismatch($sformatf("found_value %0d, expected %0d", out_found_value, e.found));
        if (out_status !== e.status)
          report_mismatch($sformatf("status %0d, expected %0d", out_status, e.status));
      end
    end
  end

  initial begin
    command_t k;
    int n;
    start = 0;
    in_opcode = OP_CLEAR;
    in_row_index = 0;
    in_col_index = 0;
    in_elem_value = 0;
    rst_n = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // directed: misses on empty list, extremes, zero cases, duplicates, unused opcodes
    pending_cmds.push_back(make_cmd(OP_SEARCH, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DELETE, 8'hff, 8'hff, 0));
    pending_cmds.push_back(make_cmd(OP_APPEND, 1, 2, 0));
    pending_cmds.push_back(make_cmd(OP_APPEND, 8'hff, 8'hff, 32'sh7fff_ffff));
    pending_cmds.push_back(make_cmd(OP_INSERT, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_INSERT, 8'hff, 8'hff, 32'sh8000_0000));
    pending_cmds.push_back(make_cmd(OP_SEARCH, 8'hff, 8'hff, 0));
    pending_cmds.push_back(make_cmd(OP_SEARCH, 0, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DELETE, 8'hff, 8'hff, 0));
    pending_cmds.push_back(make_cmd(OP_SEARCH, 8'hff, 8'hff, 0));
    pending_cmds.push_back(make_cmd(3'd5, 8'h55, 8'haa, -1));
    pending_cmds.push_back(make_cmd(3'd6, 0, 0, 0));
    pending_cmds.push_back(make_cmd(3'd7, 8'hff, 8'hff, 32'sh5555_aaaa));
    pending_cmds.push_back(make_cmd(OP_CLEAR, 8'haa, 8'h55, 32'sh2aaa_5555));
    pending_cmds.push_back(make_cmd(OP_SEARCH, 0, 0, 0));
    k = make_cmd(OP_CLEAR, 0, 0, 0);
    k.drain = 1;
    pending_cmds.push_back(k);
    // fill to full, then refused append and insert, zero append still skipped
    for (int i = 0; i < DEPTH; i++)
      pending_cmds.push_back(make_cmd(OP_APPEND, 8'(i % 4), 0, i + 1));
    pending_cmds.push_back(make_cmd(OP_APPEND, 3, 3, 9));
    pending_cmds.push_back(make_cmd(OP_INSERT, 3, 3, 9));
    pending_cmds.push_back(make_cmd(OP_APPEND, 3, 3, 0));
    pending_cmds.push_back(make_cmd(OP_DELETE, 8'd3, 0, 0));
    pending_cmds.push_back(make_cmd(OP_DELETE, 2, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SEARCH, 2, 0, 0));
    pending_cmds.push_back(make_cmd(OP_SEARCH, 1, 0, 0));
    pending_cmds.push_back(make_cmd(OP_INSERT, 1, 0, -7));
    pending_cmds.push_back(make_cmd(OP_SEARCH, 1, 0, 0));

    // random: small coordinate space so hits and duplicates are common
    n = 0;
    while (n < 450) begin
      int sel;
      logic [7:0] r, c;
      sel = $urandom_range(0, 99);
      if ($urandom_range(0, 3) == 0) begin
        r = 8'($urandom());
        c = 8'($urandom());
      end else begin
        r = 8'($urandom_range(0, 3));
        c = 8'($urandom_range(0, 3));
      end
      if (sel < 2) k = make_cmd(OP_CLEAR, r, c, rand_value());
      else if (sel < 30) k = make_cmd(OP_APPEND, r, c, rand_value());
      else if (sel < 50) k = make_cmd(OP_INSERT, r, c, rand_value());
      else if (sel < 75) k = make_cmd(OP_SEARCH, r, c, rand_value());
      else if (sel < 97) k = make_cmd(OP_DELETE, r, c, rand_value());
      else k = make_cmd(3'($urandom_range(5, 7)), r, c, rand_value());
      pending_cmds.push_back(k);
      if (n % 150 == 75) begin
        k.drain = 1;
        pending_cmds.push_back(k);
      end
      n++;
    end

    wait (pending_cmds.size() == 0 && expected_answers.size() == 0 && !start);
    repeat (2 * DEPTH + 10) @(posedge clk);
    if (error_count == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule

// File: filelist.f
rtl/core/smts_pkg.sv
rtl/core/smts_mem.sv
rtl/core/sparse_matrix_triple_store_unit.sv
rtl/core/smts_checker.sv
tb/sv/tb_sparse_matrix_triple_store_unit.sv
